[rtl/avr_pkg.sv]
// Constants, types and the arctangent table for the axis-angle rotation unit.
`timescale 1ns / 1ps
package avr_pkg;

  localparam int TABLE_LEN = 24;

  localparam logic signed [35:0] ONE30    = 36'sd1073741824;
  localparam logic signed [35:0] PI30     = 36'sd3373259426;
  localparam logic signed [35:0] HALFPI30 = 36'sd1686629713;
  localparam logic signed [35:0] TWOPI30  = 36'sd6746518852;
  localparam logic signed [33:0] GAIN30   = 34'sd652032874;
  localparam logic signed [32:0] ONE28    = 33'sd268435456;
  localparam logic signed [54:0] HALF_LSB = 55'sd536870912;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
  } carry_t;

  function automatic logic signed [33:0] atan_q30(input int unsigned idx);
    logic signed [33:0] v;
    case (idx)
      0:  v = 34'sd843314856;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;
      3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;
      5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524287;
      12: v = 34'sd262143;
      13: v = 34'sd131071;
      14: v = 34'sd65535;
      15: v = 34'sd32767;
      16: v = 34'sd16383;
      17: v = 34'sd8191;
      18: v = 34'sd4095;
      19: v = 34'sd2047;
      20: v = 34'sd1023;
      21: v = 34'sd511;
      22: v = 34'sd255;
      23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/axis_angle_vector_rotation_unit.sv]
// Pipelined rotation of a point about an axis through a pivot (Rodrigues form).
//
// Usage: one request enters on the slave stream (s_axis_*) and one rotated point
// leaves on the master stream (m_axis_*). Both use tvalid/tready; an item moves
// on a rising edge with tvalid and tready high.
// Input tdata carries point, pivot, axis and angle; output tdata carries the
// rotated point and tuser flags a clipped coordinate.
// Pipeline: one register stage per CORDIC step (CORDIC_STEPS, capped at the
// arctangent table length) plus ten stages for input capture, angle wrap and
// folding, matrix build, the multiplies, summing and saturation; the first
// stage is loaded at the accepting edge.
// Throughput: one request per cycle while the receiver takes results.
// Reset: all valid bits clear; the pipeline comes up empty and ready.
// Stall: when the output holds a result that is not taken, the whole pipeline
// freezes and s_axis_tready drops; nothing is lost or repeated, and a
// bubble at the output is filled by the next advance.
`timescale 1ns / 1ps
module axis_angle_vector_rotation_unit
  import avr_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, point_z, pivot_x, pivot_y, pivot_z, axis_x, axis_y,
  // axis_z, turn_angle
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rotated_x, rotated_y, rotated_z
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser
);

  localparam int N   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int LAT = N + 10;
  localparam int SF  = 2;
  localparam int SP  = N + 3;

  logic adv;
  logic [LAT-1:0] vld_q;

  carry_t in_car_q, w_car_q;
  logic signed [35:0] th_q, th_w_q, th_w_d, z0_d;
  logic neg0_d;

  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [33:0] z_q [N+1];
  logic               neg_q [N+1];
  carry_t             car_q [N+1];

  logic signed [33:0] c_d, s_d, c_q, s_q;
  logic signed [35:0] omc_d, omc_q;
  logic signed [31:0] uu_d [6];
  logic signed [31:0] uu_q [6];
  logic signed [32:0] dv_d [3];
  logic signed [32:0] dv_q [3];
  logic signed [15:0] u_q [3];
  logic signed [31:0] q_q [3];

  logic signed [32:0] odiag [3];
  logic signed [66:0] pd_q [3];
  logic signed [67:0] po_q [3];
  logic signed [49:0] ps_q [3];
  logic signed [31:0] uud_q [3];
  logic signed [32:0] dv1_q [3];
  logic signed [31:0] q1_q [3];

  logic signed [35:0] m_d [3][3];
  logic signed [35:0] m_q [3][3];
  logic signed [32:0] dv2_q [3];
  logic signed [31:0] q2_q [3];

  logic signed [16:0] dh [3];
  logic signed [16:0] dl [3];
  logic signed [52:0] hp_q [3][3];
  logic signed [52:0] lp_q [3][3];
  logic signed [31:0] q3_q [3];

  logic signed [54:0] hi_d [3];
  logic signed [54:0] lo_d [3];
  logic signed [54:0] hi_q [3];
  logic signed [54:0] lo_q [3];
  logic signed [31:0] q4_q [3];

  logic signed [55:0] t_d [3];
  logic signed [55:0] t_q [3];
  logic signed [31:0] q5_q [3];

  logic signed [42:0] r [3];
  logic signed [31:0] rot_d [3];
  logic signed [31:0] rot_q [3];
  logic [2:0]         clip;
  logic               sat_q;

  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = {rot_q[2], rot_q[1], rot_q[0]};
  assign m_axis_tuser  = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // input and angle range wrap, quarter-turn fold
  always_comb begin
    if (th_q > PI30) begin
      th_w_d = th_q - TWOPI30;
    end else if (th_q < -PI30) begin
      th_w_d = th_q + TWOPI30;
    end else begin
      th_w_d = th_q;
    end
    neg0_d = 1'b0;
    z0_d   = th_w_q;
    if (th_w_q > HALFPI30) begin
      z0_d   = th_w_q - PI30;
      neg0_d = 1'b1;
    end else if (th_w_q < -HALFPI30) begin
      z0_d   = th_w_q + PI30;
      neg0_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_car_q <= carry_t'({s_axis_tdata[31:0], s_axis_tdata[63:32],
                            s_axis_tdata[95:64], s_axis_tdata[127:96],
                            s_axis_tdata[159:128], s_axis_tdata[191:160],
                            s_axis_tdata[207:192], s_axis_tdata[223:208],
                            s_axis_tdata[239:224]});
      th_q     <= {{2{s_axis_tdata[255]}}, s_axis_tdata[255:240], 18'b0};
      w_car_q  <= in_car_q;
      th_w_q   <= th_w_d;
      x_q[0]   <= GAIN30;
      y_q[0]   <= '0;
      z_q[0]   <= z0_d[33:0];
      neg_q[0] <= neg0_d;
      car_q[0] <= w_car_q;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cordic
    logic signed [33:0] x_d, y_d, z_d;
    always_comb begin
      if (!z_q[k][33]) begin
        x_d = x_q[k] - (y_q[k] >>> k);
        y_d = y_q[k] + (x_q[k] >>> k);
        z_d = z_q[k] - atan_q30(k);
      end else begin
        x_d = x_q[k] + (y_q[k] >>> k);
        y_d = y_q[k] - (x_q[k] >>> k);
        z_d = z_q[k] + atan_q30(k);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[k+1]   <= x_d;
        y_q[k+1]   <= y_d;
        z_q[k+1]   <= z_d;
        neg_q[k+1] <= neg_q[k];
        car_q[k+1] <= car_q[k];
      end
    end
  end

  // cosine/sine sign, axis products, offset from pivot
  always_comb begin
    c_d      = neg_q[N] ? -x_q[N] : x_q[N];
    s_d      = neg_q[N] ? -y_q[N] : y_q[N];
    omc_d    = ONE30 - 36'(c_d);
    uu_d[0]  = car_q[N].ux * car_q[N].ux;
    uu_d[1]  = car_q[N].uy * car_q[N].uy;
    uu_d[2]  = car_q[N].uz * car_q[N].uz;
    uu_d[3]  = car_q[N].ux * car_q[N].uy;
    uu_d[4]  = car_q[N].ux * car_q[N].uz;
    uu_d[5]  = car_q[N].uy * car_q[N].uz;
    dv_d[0]  = 33'(car_q[N].px) - 33'(car_q[N].qx);
    dv_d[1]  = 33'(car_q[N].py) - 33'(car_q[N].qy);
    dv_d[2]  = 33'(car_q[N].pz) - 33'(car_q[N].qz);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q    <= c_d;
      s_q    <= s_d;
      omc_q  <= omc_d;
      uu_q   <= uu_d;
      dv_q   <= dv_d;
      u_q[0] <= car_q[N].ux;
      u_q[1] <= car_q[N].uy;
      u_q[2] <= car_q[N].uz;
      q_q[0] <= car_q[N].qx;
      q_q[1] <= car_q[N].qy;
      q_q[2] <= car_q[N].qz;
    end
  end

  // matrix term products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      odiag[i] = ONE28 - 33'(uu_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pd_q[i]  <= odiag[i] * c_q;
        po_q[i]  <= uu_q[3+i] * omc_q;
        ps_q[i]  <= u_q[i] * s_q;
        uud_q[i] <= uu_q[i];
      end
      dv1_q <= dv_q;
      q1_q  <= q_q;
    end
  end

  // matrix entries
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_d[i][i] = ({{4{uud_q[i][31]}}, uud_q[i]} <<< 2) + 36'($signed(pd_q[i][66:28]));
    end
    m_d[0][1] = 36'($signed(po_q[0][67:28])) - 36'($signed(ps_q[2][49:14]));
    m_d[1][0] = 36'($signed(po_q[0][67:28])) + 36'($signed(ps_q[2][49:14]));
    m_d[0][2] = 36'($signed(po_q[1][67:28])) + 36'($signed(ps_q[1][49:14]));
    m_d[2][0] = 36'($signed(po_q[1][67:28])) - 36'($signed(ps_q[1][49:14]));
    m_d[1][2] = 36'($signed(po_q[2][67:28])) - 36'($signed(ps_q[0][49:14]));
    m_d[2][1] = 36'($signed(po_q[2][67:28])) + 36'($signed(ps_q[0][49:14]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q   <= m_d;
      dv2_q <= dv1_q;
      q2_q  <= q1_q;
    end
  end

  // split offsets into high and low halves and multiply
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dh[j] = $signed(dv2_q[j][32:16]);
      dl[j] = $signed({1'b0, dv2_q[j][15:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          hp_q[i][j] <= m_q[i][j] * dh[j];
          lp_q[i][j] <= m_q[i][j] * dl[j];
        end
      end
      q3_q <= q2_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_d[i] = 55'(hp_q[i][0]) + 55'(hp_q[i][1]) + 55'(hp_q[i][2]);
      lo_d[i] = HALF_LSB + 55'(lp_q[i][0]) + 55'(lp_q[i][1]) + 55'(lp_q[i][2]);
      t_d[i]  = 56'(hi_q[i]) + 56'($signed(lo_q[i][54:16]));
      r[i]    = 43'($signed(t_q[i][55:14])) + 43'(q5_q[i]);
      clip[i] = 1'b0;
      rot_d[i] = r[i][31:0];
      if (r[i] > 43'sd2147483647) begin
        rot_d[i] = 32'sh7FFFFFFF;
        clip[i]  = 1'b1;
      end else if (r[i] < -43'sd2147483648) begin
        rot_d[i] = 32'sh80000000;
        clip[i]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hi_q  <= hi_d;
      lo_q  <= lo_d;
      q4_q  <= q3_q;
      t_q   <= t_d;
      q5_q  <= q4_q;
      rot_q <= rot_d;
      sat_q <= |clip;
    end
  end

`ifndef NO_ASSERTIONS
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted request not captured");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SF] |-> (36'(z_q[0]) <= HALFPI30) && (36'(z_q[0]) >= -HALFPI30))
    else $error("folded angle out of quarter turn");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      rot_q[0] == 32'sh7FFFFFFF || rot_q[0] == 32'sh80000000 ||
      rot_q[1] == 32'sh7FFFFFFF || rot_q[1] == 32'sh80000000 ||
      rot_q[2] == 32'sh7FFFFFFF || rot_q[2] == 32'sh80000000)
    else $error("saturation flag without clipped coordinate");

  a_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SP] |-> (omc_q == ONE30 - 36'(c_q)))
    else $error("one minus cosine mismatch");
`endif

endmodule
